@@ sv/bts_pkg.sv @@
// Shared constants, types and register indexes of the bilinear texel sampler.
package bts_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W     = XW + YW;
  localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned PER_W      = DIM_W + 1;
  localparam int unsigned REM_W      = DIM_W;
  localparam int unsigned CRD_W      = 32;
  localparam int unsigned SX_W       = CRD_W + PER_W - 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TAP_W      = SX_W - FRAC_W;
  localparam int unsigned MAG_W      = TAP_W - 1;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned NSTEP      = MAG_W / DIG_W;
  localparam int unsigned FOLD_LAT   = NSTEP + 2;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned N_CH       = 4;
  localparam int unsigned TEXEL_W    = CH_W * N_CH;
  localparam int unsigned IN_DATA_W  = 2 * CRD_W + XW + YW + TEXEL_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam logic [SX_W-1:0] HALF_TEXEL = SX_W'(32768);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_U = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_V = 2'd3;

  typedef struct packed {
    logic valid;
    logic sample;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [XW-1:0]     wx;
    logic [YW-1:0]     wy;
    logic [TEXEL_W-1:0] rgba;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } side_t;

endpackage

@@ sv/bts_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bts_fold.sv @@
// Pipelined tap folding: floor modulo by the period, then wrap or mirror.
module bts_fold import bts_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [TAP_W-1:0] tap_i,
  input  logic [DIM_W-1:0]        size_i,
  input  logic                    mirror_i,
  output logic [XW-1:0]           a0_o,
  output logic [XW-1:0]           a1_o
);

  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] rem,
                                                input logic [DIG_W-1:0] dig,
                                                input logic [PER_W-1:0] per);
    logic [PER_W-1:0] t;
    logic [REM_W-1:0] r;
    r = rem;
    for (int i = DIG_W - 1; i >= 0; i--) begin
      t = {r, dig[i]};
      if (t >= per) begin
        t = t - per;
      end
      r = t[REM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] reflect(input logic [REM_W-1:0] a,
                                            input logic [DIM_W-1:0] size,
                                            input logic [PER_W-1:0] per,
                                            input logic mirror);
    logic [PER_W-1:0] t;
    t = {1'b0, a};
    if (mirror && (a >= size)) begin
      t = per - PER_W'(1) - {1'b0, a};
    end
    return t[XW-1:0];
  endfunction

  logic [PER_W-1:0] period;
  logic             neg_q [NSTEP+1];
  logic [MAG_W-1:0] mag_q [NSTEP];
  logic [REM_W-1:0] rem_q [NSTEP+1];
  logic [TAP_W-1:0] neg_tap;
  logic [REM_W-1:0] r0, r1;
  logic [PER_W-1:0] r1n;
  logic [XW-1:0]    a0_q, a1_q;

  assign period  = mirror_i ? {size_i, 1'b0} : {1'b0, size_i};
  assign neg_tap = -tap_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= tap_i[TAP_W-1];
      mag_q[0] <= tap_i[TAP_W-1] ? neg_tap[MAG_W-1:0] : tap_i[MAG_W-1:0];
      rem_q[0] <= '0;
      for (int s = 1; s <= NSTEP; s++) begin
        neg_q[s] <= neg_q[s-1];
        rem_q[s] <= mod_step(rem_q[s-1], mag_q[s-1][MAG_W-1-DIG_W*(s-1) -: DIG_W], period);
      end
      for (int s = 1; s < NSTEP; s++) begin
        mag_q[s] <= mag_q[s-1];
      end
      a0_q <= reflect(r0, size_i, period, mirror_i);
      a1_q <= reflect(r1, size_i, period, mirror_i);
    end
  end

  always_comb begin
    r0 = rem_q[NSTEP];
    if (neg_q[NSTEP] && (rem_q[NSTEP] != '0)) begin
      r0 = REM_W'(period - {1'b0, rem_q[NSTEP]});
    end
    r1n = {1'b0, r0} + PER_W'(1);
    r1  = (r1n == period) ? '0 : r1n[REM_W-1:0];
  end

  assign a0_o = a0_q;
  assign a1_o = a1_q;

endmodule

@@ sv/bts_filter.sv @@
// Two-stage bilinear blend of four texels per channel with rounding and clamp.
module bts_filter import bts_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ctl_t                         ctl_i,
  input  logic [TEXEL_W-1:0]           tl_i,
  input  logic [TEXEL_W-1:0]           tr_i,
  input  logic [TEXEL_W-1:0]           bl_i,
  input  logic [TEXEL_W-1:0]           br_i,
  input  logic [FRAC_W-1:0]            fx_i,
  input  logic [FRAC_W-1:0]            fy_i,
  output ctl_t                         ctl_o,
  output logic [N_CH-1:0][CH_W-1:0]    chan_o
);

  localparam int unsigned LERP_W = CH_W + FRAC_W + 2;
  localparam int unsigned PROD_W = LERP_W + FRAC_W + 2;
  localparam int unsigned VAL_W  = LERP_W + FRAC_W + 6;

  ctl_t                     ctl_q;
  logic [FRAC_W-1:0]        fy_q;
  logic signed [LERP_W-1:0] top_q [N_CH];
  logic signed [LERP_W-1:0] bot_q [N_CH];
  logic signed [LERP_W-1:0] top_d [N_CH];
  logic signed [LERP_W-1:0] bot_d [N_CH];

  always_comb begin
    logic signed [CH_W+1:0]  a, b, d, e;
    logic signed [FRAC_W:0]  fx;
    fx = signed'({1'b0, fx_i});
    for (int c = 0; c < N_CH; c++) begin
      a = signed'({2'b00, tl_i[c*CH_W +: CH_W]});
      b = signed'({2'b00, tr_i[c*CH_W +: CH_W]});
      d = signed'({2'b00, bl_i[c*CH_W +: CH_W]});
      e = signed'({2'b00, br_i[c*CH_W +: CH_W]});
      top_d[c] = (LERP_W'(a) <<< FRAC_W) + LERP_W'((b - a) * fx);
      bot_d[c] = (LERP_W'(d) <<< FRAC_W) + LERP_W'((e - d) * fx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fy_q <= fy_i;
      for (int c = 0; c < N_CH; c++) begin
        top_q[c] <= top_d[c];
        bot_q[c] <= bot_d[c];
      end
    end
  end

  always_comb begin
    logic signed [VAL_W-1:0]  val;
    logic signed [LERP_W:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [FRAC_W:0]   fy;
    fy = signed'({1'b0, fy_q});
    for (int c = 0; c < N_CH; c++) begin
      diff = {bot_q[c][LERP_W-1], bot_q[c]} - {top_q[c][LERP_W-1], top_q[c]};
      prod = diff * fy;
      val = (VAL_W'(top_q[c]) <<< FRAC_W)
          + VAL_W'(prod)
          + (VAL_W'(1) <<< (2 * FRAC_W - 1));
      if (val < 0) begin
        chan_o[c] = '0;
      end else if (val[VAL_W-1:2*FRAC_W] > (VAL_W-2*FRAC_W)'(255)) begin
        chan_o[c] = '1;
      end else begin
        chan_o[c] = val[2*FRAC_W +: CH_W];
      end
    end
  end

  assign ctl_o = ctl_q;

endmodule

@@ sv/bilinear_texel_sampler.sv @@
// Top level of the bilinear texel sampler.
// Takes one transaction per clock cycle, texel writes and samples alike, unless
// a finished sample waits on a full output register that m_axis does not take.
// A transaction passes the coordinate scaling multiply register, the tap folding
// pipeline (a modulo by the image period that retires four tap bits per stage,
// then the wrap or mirror fix-up), the texel store read and the blend and output
// registers. The image lives in four replicated 256x256 RGBA8 stores, one per
// bilinear tap, so every sample reads its four texels at once; a write updates
// all four copies. Texel writes give no result. Write image_width, image_height,
// mode_u and mode_v only while no transaction is in flight.
module bilinear_texel_sampler import bts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // u_coord, v_coord, write_x, write_y, write_rgba
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // chan_zero, chan_one, chan_two, chan_three
  output logic [TEXEL_W-1:0]    m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DIM_W-1:0] width_q, height_q;
  logic             mode_u_q, mode_v_q;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             empty;

  logic                   en;
  logic                   accept;
  logic signed [SX_W-1:0] sx_d, sy_d;
  logic signed [SX_W-1:0] sx_q, sy_q;
  side_t                  side_d;
  side_t                  side_q [FOLD_LAT+1];
  side_t                  last;

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic          ram_we;
  logic [ADDR_W-1:0] waddr;
  logic [TEXEL_W-1:0] tl, tr, bl, br;

  ctl_t              rd_ctl_q;
  logic [FRAC_W-1:0] rd_fx_q, rd_fy_q;
  ctl_t              f_ctl;
  logic [N_CH-1:0][CH_W-1:0] f_chan;
  logic              f_sample;

  logic                 out_v_q;
  logic [TEXEL_W-1:0]   out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      mode_u_q <= 1'b0;
      mode_v_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_MODE_U: mode_u_q <= cfg_data_i[0];
        REG_MODE_V: mode_v_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
  assign empty = (w_eff == '0) || (h_eff == '0);

  assign f_sample        = f_ctl.valid && f_ctl.sample;
  assign en              = !out_v_q || m_axis_tready_i || !f_sample;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  assign sx_d = SX_W'(signed'(s_axis_tdata_i[CRD_W-1:0]) * signed'({1'b0, w_eff}))
              - signed'(HALF_TEXEL);
  assign sy_d = SX_W'(signed'(s_axis_tdata_i[2*CRD_W-1:CRD_W]) * signed'({1'b0, h_eff}))
              - signed'(HALF_TEXEL);

  always_comb begin
    side_d.ctl.valid  = accept;
    side_d.ctl.sample = s_axis_tuser_i == OP_SAMPLE;
    side_d.wx   = s_axis_tdata_i[2*CRD_W +: XW];
    side_d.wy   = s_axis_tdata_i[2*CRD_W+XW +: YW];
    side_d.rgba = s_axis_tdata_i[2*CRD_W+XW+YW +: TEXEL_W];
    side_d.fx   = sx_d[FRAC_W-1:0];
    side_d.fy   = sy_d[FRAC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= FOLD_LAT; s++) begin
        side_q[s] <= '0;
      end
    end else if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s <= FOLD_LAT; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  bts_fold u_fold_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .tap_i    (sx_q[SX_W-1:FRAC_W]),
    .size_i   (w_eff),
    .mirror_i (mode_u_q),
    .a0_o     (x0),
    .a1_o     (x1)
  );

  bts_fold u_fold_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .tap_i    (sy_q[SX_W-1:FRAC_W]),
    .size_i   (h_eff),
    .mirror_i (mode_v_q),
    .a0_o     (y0),
    .a1_o     (y1)
  );

  assign last   = side_q[FOLD_LAT];
  assign ram_we = en && last.ctl.valid && (last.ctl.sample == OP_WRITE);
  assign waddr  = {last.wy, last.wx};

  bts_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_tl (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (last.rgba),
    .re_i (en), .raddr_i ({y0, x0}), .rdata_o (tl)
  );

  bts_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_tr (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (last.rgba),
    .re_i (en), .raddr_i ({y0, x1}), .rdata_o (tr)
  );

  bts_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_bl (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (last.rgba),
    .re_i (en), .raddr_i ({y1, x0}), .rdata_o (bl)
  );

  bts_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_br (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (last.rgba),
    .re_i (en), .raddr_i ({y1, x1}), .rdata_o (br)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else if (en) begin
      rd_ctl_q <= last.ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_fx_q <= last.fx;
      rd_fy_q <= last.fy;
    end
  end

  bts_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (rd_ctl_q),
    .tl_i   (tl),
    .tr_i   (tr),
    .bl_i   (bl),
    .br_i   (br),
    .fx_i   (rd_fx_q),
    .fy_i   (rd_fy_q),
    .ctl_o  (f_ctl),
    .chan_o (f_chan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en && f_sample) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && f_sample) begin
      out_q <= empty ? '0 : f_chan;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_x_taps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.ctl.valid && last.ctl.sample && !empty)
      |-> ({1'b0, x0} < w_eff) && ({1'b0, x1} < w_eff))
    else $error("horizontal tap outside image");

  a_y_taps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.ctl.valid && last.ctl.sample && !empty)
      |-> ({1'b0, y0} < h_eff) && ({1'b0, y1} < h_eff))
    else $error("vertical tap outside image");
`endif

endmodule

@@ tb/tb_bilinear_texel_sampler.sv @@
// Testbench of the bilinear texel sampler: filtered samples checked against a predictor.
class texel_scoreboard;
  logic [31:0] texels [65536];
  logic [31:0] expected_pixels [$];
  int unsigned img_w, img_h;
  bit mir_u, mir_v;

  function void set_reg(logic [1:0] idx, logic [8:0] val);
    case (idx)
      bts_pkg::REG_WIDTH:  img_w = 32'(val);
      bts_pkg::REG_HEIGHT: img_h = 32'(val);
      bts_pkg::REG_MODE_U: mir_u = val[0];
      default:             mir_v = val[0];
    endcase
  endfunction

  function longint fold(longint t, longint n, bit m);
    longint p, a;
    p = m ? 2 * n : n;
    a = t % p;
    if (a < 0) a += p;
    if (m && a >= n) a = p - 1 - a;
    return a;
  endfunction

  function void note_accepted(logic op, logic [31:0] u, logic [31:0] v, logic [7:0] x,
                              logic [7:0] y, logic [31:0] rgba);
    longint w, h, sx, sy, fx, fy, tx, ty, a, b, d, e, top, bot, val, r;
    longint x0, x1, y0, y1;
    logic [31:0] tl, tr, bl, br, px;
    if (op == bts_pkg::OP_WRITE) begin
      texels[{y, x}] = rgba;
      return;
    end
    px = '0;
    w = (img_w > 256) ? 256 : img_w;
    h = (img_h > 256) ? 256 : img_h;
    if (w != 0 && h != 0) begin
      sx = longint'($signed(u)) * w - 32768;
      sy = longint'($signed(v)) * h - 32768;
      fx = sx & 64'hFFFF;
      fy = sy & 64'hFFFF;
      tx = (sx - fx) / 65536;
      ty = (sy - fy) / 65536;
      x0 = fold(tx, w, mir_u);
      x1 = fold(tx + 1, w, mir_u);
      y0 = fold(ty, h, mir_v);
      y1 = fold(ty + 1, h, mir_v);
      tl = texels[y0 * 256 + x0];
      tr = texels[y0 * 256 + x1];
      bl = texels[y1 * 256 + x0];
      br = texels[y1 * 256 + x1];
      for (int c = 0; c < 4; c++) begin
        a = tl[c*8 +: 8];
        b = tr[c*8 +: 8];
        d = bl[c*8 +: 8];
        e = br[c*8 +: 8];
        top = a * 65536 + (b - a) * fx;
        bot = d * 65536 + (e - d) * fx;
        val = top * 65536 + (bot - top) * fy + (64'sd1 <<< 31);
        r = (val < 0) ? 0 : val / (64'sd1 <<< 32);
        if (r > 255) r = 255;
        px[c*8 +: 8] = r[7:0];
      end
    end
    expected_pixels.push_back(px);
  endfunction

  function bit check_result(logic [31:0] got, output logic [31:0] exp_px, output bit [3:0] bad);
    bad = '0;
    exp_px = '0;
    if (expected_pixels.size() == 0) return 0;
    exp_px = expected_pixels.pop_front();
    for (int c = 0; c < 4; c++) bad[c] = (got[c*8 +: 8] !== exp_px[c*8 +: 8]);
    return 1;
  endfunction
endclass

module tb_bilinear_texel_sampler import bts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [TEXEL_W-1:0]    m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  texel_scoreboard sb = new();
  int unsigned errors = 0;
  int unsigned cur_w, cur_h;
  bit calm = 0;

  bilinear_texel_sampler uut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
    m_axis_tready_i <= (gap_len() == 0);
  end

  always @(negedge clk_i) begin
    logic [31:0] exp_px;
    bit [3:0] bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (!sb.check_result(m_axis_tdata_o, exp_px, bad))
        report($sformatf("unexpected result %h", m_axis_tdata_o));
      else
        for (int c = 0; c < 4; c++)
          if (bad[c])
            report($sformatf("channel %0d got %h exp %h", c, m_axis_tdata_o[c*8 +: 8],
                             exp_px[c*8 +: 8]));
    end
  end

  task automatic send_item(logic op, logic [31:0] u, logic [31:0] v, logic [7:0] x,
                           logic [7:0] y, logic [31:0] rgba);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {rgba, y, x, v, u};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_accepted(op, u, v, x, y, rgba);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, bit mu, bit mv);
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE_U, {8'd0, mu});
    write_reg(REG_MODE_V, {8'd0, mv});
    cfg_valid_i <= 1'b0;
    cur_w = (w > 256) ? 256 : 32'(w);
    cur_h = (h > 256) ? 256 : 32'(h);
  endtask

  function automatic logic [31:0] rand_texel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h30000) - 32'h10000;
    return $urandom;
  endfunction

  task automatic fill_image();
    for (int y = 0; y < cur_h; y++)
      for (int x = 0; x < cur_w; x++)
        send_item(OP_WRITE, $urandom, $urandom, 8'(x), 8'(y), rand_texel());
  endtask

  task automatic directed_samples();
    logic [31:0] pts [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000, 32'h1_0000,
                             32'hFFFF_FFFF};
    foreach (pts[i]) send_item(OP_SAMPLE, pts[i], pts[5 - i], 8'hFF, 8'h00, '1);
  endtask

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        if ($urandom_range(0, 1) && cur_w != 0 && cur_h != 0)
          send_item(OP_WRITE, $urandom, $urandom, 8'($urandom_range(0, cur_w - 1)),
                    8'($urandom_range(0, cur_h - 1)), rand_texel());
        else
          send_item(OP_WRITE, $urandom, $urandom, 8'($urandom), 8'($urandom), $urandom);
      end else begin
        send_item(OP_SAMPLE, rand_coord(), rand_coord(), 8'($urandom), 8'($urandom),
                  $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure(9'd0, 9'd0, 1'b0, 1'b0);
    directed_samples();
    configure(9'd1, 9'd1, 1'b0, 1'b0);
    fill_image();
    directed_samples();
    configure(9'd511, 9'd1, 1'b0, 1'b1);
    fill_image();
    directed_samples();
    random_phase(10);
    configure(9'd1, 9'd256, 1'b1, 1'b1);
    fill_image();
    directed_samples();
    random_phase(10);
    configure(9'd3, 9'd0, 1'b1, 1'b0);
    directed_samples();
    for (int p = 0; p < 14; p++) begin
      configure(9'($urandom_range(1, 8)), 9'($urandom_range(1, 6)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      fill_image();
      random_phase(12);
    end
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
